// File: rtl/core/pva_pkg.sv
// Shared types and constants for the priority voice allocator.
// Used by pva_ctrl, pva_dp and the priority_voice_allocator top level.
`default_nettype none

package pva_pkg;

  localparam int HANDLE_W   = 12;
  localparam int ENTITY_W   = 10;
  localparam int SLOT_W     = 4;
  localparam int SOUND_W    = 10;
  localparam int PRIO_W     = 8;
  localparam int TIME_W     = 32;
  localparam int VIDX_W     = 5;
  localparam int ACTIVE_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Operation codes of an input item.
  localparam logic OP_PICK    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_EMITTER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LISTENER_ENTITY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } pva_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // latch a new item and clear the search state
    logic scan;    // step the table scan by one entry
    logic commit;  // write back the voice table and load the result
  } pva_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic free_hit;  // the entry under the scan pointer is free
    logic scan_end;  // every voice in use has been issued
    logic out_free;  // the result register can take a result this cycle
  } pva_sts_t;

  // One stored voice record.
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [ENTITY_W-1:0] entity;
    logic [SLOT_W-1:0]   slot;
    logic [SOUND_W-1:0]  sound;
    logic [PRIO_W-1:0]   prio;
    logic                no_restart;
    logic                no_override;
    logic [TIME_W-1:0]   alloc_time;
  } voice_entry_t;

  // The item being worked on.
  typedef struct packed {
    logic                operation;
    voice_entry_t        entry;
    logic [VIDX_W-1:0]   release_index;
  } pva_req_t;

endpackage

`default_nettype wire

// File: rtl/core/pva_ctrl.sv
// Controller state machine of the priority voice allocator.
// Depends on pva_pkg for the state, command and status types.
`default_nettype none

module pva_ctrl
  import pva_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_operation,
  output logic          in_stall,
  input  wire pva_sts_t sts,
  output pva_cmd_t      cmd
);

  pva_state_t state_r;
  pva_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_operation == OP_RELEASE) ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.free_hit) begin
          state_nxt = ST_FIN;
        end else if (sts.scan_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd.start  = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_FIN: begin
        cmd.commit = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/pva_dp.sv
// Datapath of the priority voice allocator: configuration registers, busy
// flags, voice record memory, steal search and result register. Uses pva_pkg.
`default_nettype none

module pva_dp
  import pva_pkg::*;
#(
  parameter int NUM_VOICES = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_operation,
  input  wire logic [HANDLE_W-1:0]   in_emitter_handle,
  input  wire logic [ENTITY_W-1:0]   in_entity_number,
  input  wire logic [SLOT_W-1:0]     in_slot,
  input  wire logic [SOUND_W-1:0]    in_sound_id,
  input  wire logic [PRIO_W-1:0]     in_priority_req,
  input  wire logic                  in_no_restart,
  input  wire logic                  in_no_override,
  input  wire logic [TIME_W-1:0]     in_now,
  input  wire logic [VIDX_W-1:0]     in_release_index,
  input  wire pva_cmd_t              cmd,
  output pva_sts_t                   sts,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_granted,
  output logic [VIDX_W-1:0]          out_voice_index,
  output logic                       out_stolen
);

  localparam int IDX_W = $clog2(NUM_VOICES);
  localparam int CNT_W = $clog2(NUM_VOICES + 1);
  localparam int EXT_W = IDX_W + VIDX_W;

  // Configuration.
  logic [ACTIVE_W-1:0] active_r;
  logic [HANDLE_W-1:0] local_r;
  logic [ENTITY_W-1:0] listener_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= ACTIVE_W'(32);
      local_r    <= '0;
      listener_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ACTIVE_CHANNELS: active_r   <= cfg_wdata[ACTIVE_W-1:0];
        CFG_LOCAL_EMITTER:   local_r    <= cfg_wdata[HANDLE_W-1:0];
        CFG_LISTENER_ENTITY: listener_r <= cfg_wdata[ENTITY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic [CNT_W-1:0] used_n;
  assign used_n = (32'(active_r) > 32'(NUM_VOICES)) ? CNT_W'(NUM_VOICES) : CNT_W'(active_r);

  // Request register.
  pva_req_t req_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r.operation         <= in_operation;
      req_r.entry.handle      <= in_emitter_handle;
      req_r.entry.entity      <= in_entity_number;
      req_r.entry.slot        <= in_slot;
      req_r.entry.sound       <= in_sound_id;
      req_r.entry.prio        <= in_priority_req;
      req_r.entry.no_restart  <= in_no_restart;
      req_r.entry.no_override <= in_no_override;
      req_r.entry.alloc_time  <= in_now;
      req_r.release_index     <= in_release_index;
    end
  end

  // Scan pointer and the read pipeline stage of the voice memory.
  logic [CNT_W-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic [IDX_W-1:0]  scan_idx;
  logic [NUM_VOICES-1:0] busy_r;
  logic              scan_end;
  logic              free_hit;
  logic              rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]  rd_idx_r;
  voice_entry_t      rd_data_r;
  voice_entry_t      mem_r [NUM_VOICES];

  assign scan_idx   = scan_cnt_r[IDX_W-1:0];
  assign scan_end   = (scan_cnt_r >= used_n);
  assign free_hit   = !scan_end && !busy_r[scan_idx];
  assign rd_vld_nxt = cmd.scan && !scan_end && busy_r[scan_idx];

  // Steal search on the entry coming out of the memory.
  logic              best_vld_r, best_vld_nxt;
  logic              lock_r, lock_nxt;
  logic              free_r, free_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [PRIO_W-1:0] best_prio_r, best_prio_nxt;
  logic [TIME_W-1:0] best_time_r, best_time_nxt;
  logic              skip, match, forbid, better, take;

  always_comb begin
    skip = ((rd_data_r.handle == local_r) && (req_r.entry.handle != local_r)) ||
           ((rd_data_r.entity == listener_r) && (req_r.entry.entity != listener_r)) ||
           (rd_data_r.prio > req_r.entry.prio);
    match = (req_r.entry.slot != '0) && (rd_data_r.handle == req_r.entry.handle) &&
            (rd_data_r.slot == req_r.entry.slot);
    forbid = (rd_data_r.sound == req_r.entry.sound) ? rd_data_r.no_restart
                                                     : rd_data_r.no_override;
    better = !best_vld_r || (rd_data_r.prio < best_prio_r) ||
             ((rd_data_r.prio == best_prio_r) && (rd_data_r.alloc_time < best_time_r));
    take = rd_vld_r && !lock_r && !skip && (match ? !forbid : better);
  end

  always_comb begin
    scan_cnt_nxt  = scan_cnt_r;
    best_vld_nxt  = best_vld_r;
    lock_nxt      = lock_r;
    free_nxt      = free_r;
    best_idx_nxt  = best_idx_r;
    best_prio_nxt = best_prio_r;
    best_time_nxt = best_time_r;
    if (cmd.start) begin
      scan_cnt_nxt = '0;
      best_vld_nxt = 1'b0;
      lock_nxt     = 1'b0;
      free_nxt     = 1'b0;
    end else begin
      if (take) begin
        best_vld_nxt  = 1'b1;
        best_idx_nxt  = rd_idx_r;
        best_prio_nxt = rd_data_r.prio;
        best_time_nxt = rd_data_r.alloc_time;
        // A same emitter and slot hit ends the steal search, though the scan
        // goes on because a free voice further up still wins.
        lock_nxt      = match;
      end
      if (cmd.scan && free_hit) begin
        free_nxt     = 1'b1;
        best_idx_nxt = scan_idx;
      end
      if (rd_vld_nxt) begin
        scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      rd_vld_r   <= 1'b0;
      best_vld_r <= 1'b0;
      lock_r     <= 1'b0;
      free_r     <= 1'b0;
    end else begin
      scan_cnt_r <= scan_cnt_nxt;
      rd_vld_r   <= rd_vld_nxt;
      best_vld_r <= best_vld_nxt;
      lock_r     <= lock_nxt;
      free_r     <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= scan_idx;
    best_idx_r  <= best_idx_nxt;
    best_prio_r <= best_prio_nxt;
    best_time_r <= best_time_nxt;
  end

  // Result of the item and writeback.
  logic [EXT_W-1:0]  rel_ext;
  logic [IDX_W-1:0]  rel_idx;
  logic              rel_in_range;
  logic [EXT_W-1:0]  best_ext;
  logic              fin_granted;
  logic [VIDX_W-1:0] fin_vidx;
  logic              fin_stolen;
  logic              pick_wr;

  assign rel_ext      = EXT_W'(req_r.release_index);
  assign rel_idx      = rel_ext[IDX_W-1:0];
  assign rel_in_range = (32'(req_r.release_index) < 32'(NUM_VOICES));
  assign best_ext     = EXT_W'(best_idx_r);

  always_comb begin
    fin_granted = 1'b0;
    fin_vidx    = '0;
    fin_stolen  = 1'b0;
    if (req_r.operation == OP_RELEASE) begin
      fin_granted = rel_in_range && busy_r[rel_idx];
      fin_vidx    = req_r.release_index;
    end else if (free_r || best_vld_r) begin
      fin_granted = 1'b1;
      fin_vidx    = best_ext[VIDX_W-1:0];
      fin_stolen  = !free_r;
    end
  end

  assign pick_wr = cmd.commit && (req_r.operation == OP_PICK) && fin_granted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else if (cmd.commit && fin_granted) begin
      if (req_r.operation == OP_RELEASE) begin
        busy_r[rel_idx] <= 1'b0;
      end else begin
        busy_r[best_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pick_wr) begin
      mem_r[best_idx_r] <= req_r.entry;
    end
    if (rd_vld_nxt) begin
      rd_data_r <= mem_r[scan_idx];
    end
  end

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  logic              out_granted_r;
  logic [VIDX_W-1:0] out_vidx_r;
  logic              out_stolen_r;

  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.free_hit = free_hit;
  assign sts.scan_end = scan_end;
  assign out_valid_nxt = cmd.commit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_granted_r <= fin_granted;
      out_vidx_r    <= fin_vidx;
      out_stolen_r  <= fin_stolen;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_granted     = out_granted_r;
  assign out_voice_index = out_vidx_r;
  assign out_stolen      = out_stolen_r;

endmodule

`default_nettype wire

// File: rtl/core/priority_voice_allocator.sv
// Top level of the priority voice allocator: joins pva_ctrl and pva_dp.
// Depends on pva_pkg, pva_ctrl and pva_dp.
`default_nettype none

// A pick item returns the lowest free voice among the first n voices, where
// n is active_channels limited to NUM_VOICES; with none free it steals the
// best qualifying busy voice, or drops the item with an all-zero result. One
// item is worked on at a time. The voice records sit in a memory with one
// read port, so the scan reads one voice per cycle. A pick whose scan covers
// all n voices reads them in turn, compares the last read as the scan ends,
// passes the drain state and then loads the result register in the writeback
// state. The scan stops early at the first free voice and goes straight to
// writeback; a release goes from acceptance straight to writeback. The next
// item is taken in the cycle after the load. A held result stalls only the
// writeback of the next item; the next item is accepted while the result waits.
module priority_voice_allocator
  import pva_pkg::*;
#(
  parameter int NUM_VOICES = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_operation,
  input  wire logic [HANDLE_W-1:0]   in_emitter_handle,
  input  wire logic [ENTITY_W-1:0]   in_entity_number,
  input  wire logic [SLOT_W-1:0]     in_slot,
  input  wire logic [SOUND_W-1:0]    in_sound_id,
  input  wire logic [PRIO_W-1:0]     in_priority_req,
  input  wire logic                  in_no_restart,
  input  wire logic                  in_no_override,
  input  wire logic [TIME_W-1:0]     in_now,
  input  wire logic [VIDX_W-1:0]     in_release_index,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_granted,
  output logic [VIDX_W-1:0]          out_voice_index,
  output logic                       out_stolen
);

  pva_cmd_t cmd;
  pva_sts_t sts;

  pva_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  pva_dp #(
    .NUM_VOICES (NUM_VOICES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_operation      (in_operation),
    .in_emitter_handle (in_emitter_handle),
    .in_entity_number  (in_entity_number),
    .in_slot           (in_slot),
    .in_sound_id       (in_sound_id),
    .in_priority_req   (in_priority_req),
    .in_no_restart     (in_no_restart),
    .in_no_override    (in_no_override),
    .in_now            (in_now),
    .in_release_index  (in_release_index),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_granted       (out_granted),
    .out_voice_index   (out_voice_index),
    .out_stolen        (out_stolen)
  );

  // A result is only loaded when the result register can take it.
  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free)
    else $error("result loaded over a waiting result");

  // Only one command at a time.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.start, cmd.scan, cmd.commit}))
    else $error("overlapping controller commands");

  // After an item is taken, the input stays stalled until its result is loaded.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item accepted while one is in progress");

  // A stolen voice is always a granted one.
  a_stolen_granted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_stolen || out_granted))
    else $error("stolen result without a grant");

endmodule

`default_nettype wire

// File: bench/voice_table_checker.sv
// Checker for the priority voice allocator: follows the configuration port and both
// item channels, keeps its own voice table and compares every result item.
// Depends on pva_pkg for widths, operation codes and register indexes.
module voice_table_checker
  import pva_pkg::*;
#(
  parameter int NUM_VOICES = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_operation,
  input  logic [HANDLE_W-1:0]   in_emitter_handle,
  input  logic [ENTITY_W-1:0]   in_entity_number,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [SOUND_W-1:0]    in_sound_id,
  input  logic [PRIO_W-1:0]     in_priority_req,
  input  logic                  in_no_restart,
  input  logic                  in_no_override,
  input  logic [TIME_W-1:0]     in_now,
  input  logic [VIDX_W-1:0]     in_release_index,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_granted,
  input  logic [VIDX_W-1:0]     out_voice_index,
  input  logic                  out_stolen,
  output int                    pending,
  output int                    fail_count
);

  typedef struct packed {
    logic              granted;
    logic [VIDX_W-1:0] voice;
    logic              stolen;
  } alloc_result_t;

  logic [ACTIVE_W-1:0]   active_cfg;
  logic [HANDLE_W-1:0]   local_cfg;
  logic [ENTITY_W-1:0]   listener_cfg;
  logic [NUM_VOICES-1:0] voice_busy;
  voice_entry_t          voice_rec [NUM_VOICES];
  alloc_result_t         grant_queue [$];
  int                    mismatches = 0;

  // Applies one item to the local voice table and returns the result it must cause.
  function automatic alloc_result_t predict_voice(input pva_req_t item);
    alloc_result_t res;
    int            n;
    int            pick;
    logic          slot_hit;
    logic          blocked;
    logic          same_slot;
    logic          may_replace;
    res = '0;
    pick = -1;
    slot_hit = 1'b0;
    if (item.operation == OP_RELEASE) begin
      res.voice = item.release_index;
      if (voice_busy[item.release_index]) begin
        voice_busy[item.release_index] = 1'b0;
        res.granted = 1'b1;
      end
      return res;
    end
    n = (int'(active_cfg) > NUM_VOICES) ? NUM_VOICES : int'(active_cfg);
    for (int i = 0; i < n; i++) begin
      if (pick < 0 && !voice_busy[i])
        pick = i;
    end
    if (pick < 0) begin
      // Every voice in use is busy, so look for one to steal.
      for (int i = 0; i < n && !slot_hit; i++) begin
        blocked = (voice_rec[i].handle == local_cfg && item.entry.handle != local_cfg) ||
                  (voice_rec[i].entity == listener_cfg &&
                   item.entry.entity != listener_cfg) ||
                  (voice_rec[i].prio > item.entry.prio);
        same_slot = item.entry.slot != '0 && voice_rec[i].handle == item.entry.handle &&
                    voice_rec[i].slot == item.entry.slot;
        may_replace = (voice_rec[i].sound == item.entry.sound) ?
                      !voice_rec[i].no_restart : !voice_rec[i].no_override;
        if (!blocked && same_slot) begin
          // The emitter's own slot ends the search, unless its flags forbid it.
          if (may_replace) begin
            pick = i;
            slot_hit = 1'b1;
          end
        end else if (!blocked) begin
          if (pick < 0 || voice_rec[i].prio < voice_rec[pick].prio ||
              (voice_rec[i].prio == voice_rec[pick].prio &&
               voice_rec[i].alloc_time < voice_rec[pick].alloc_time))
            pick = i;
        end
      end
      res.stolen = (pick >= 0);
    end
    if (pick >= 0) begin
      voice_busy[pick] = 1'b1;
      voice_rec[pick] = item.entry;
      res.granted = 1'b1;
      res.voice = VIDX_W'(pick);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    pva_req_t      req;
    alloc_result_t want;
    if (!rst_n) begin
      active_cfg = ACTIVE_W'(32);
      local_cfg = '0;
      listener_cfg = '0;
      voice_busy = '0;
      grant_queue.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ACTIVE_CHANNELS: active_cfg = cfg_wdata[ACTIVE_W-1:0];
          CFG_LOCAL_EMITTER:   local_cfg = cfg_wdata[HANDLE_W-1:0];
          CFG_LISTENER_ENTITY: listener_cfg = cfg_wdata[ENTITY_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        req.operation = in_operation;
        req.entry.handle = in_emitter_handle;
        req.entry.entity = in_entity_number;
        req.entry.slot = in_slot;
        req.entry.sound = in_sound_id;
        req.entry.prio = in_priority_req;
        req.entry.no_restart = in_no_restart;
        req.entry.no_override = in_no_override;
        req.entry.alloc_time = in_now;
        req.release_index = in_release_index;
        grant_queue.push_back(predict_voice(req));
      end
      if (out_valid && !out_stall) begin
        if (grant_queue.size() == 0) begin
          $error("result with no item waiting: granted %0d voice %0d stolen %0d",
                 out_granted, out_voice_index, out_stolen);
          mismatches++;
        end else begin
          want = grant_queue.pop_front();
          if (out_granted !== want.granted) begin
            $error("granted: expected %0d, got %0d", want.granted, out_granted);
            mismatches++;
          end
          if (out_voice_index !== want.voice) begin
            $error("voice_index: expected %0d, got %0d", want.voice, out_voice_index);
            mismatches++;
          end
          if (out_stolen !== want.stolen) begin
            $error("stolen: expected %0d, got %0d", want.stolen, out_stolen);
            mismatches++;
          end
        end
      end
    end
    pending <= grant_queue.size();
    fail_count <= mismatches;
  end

endmodule

// File: bench/testbench.sv
// Top of the allocator bench: clock, reset, configuration phases, directed and random
// items with random idling on both channels, and the verdict.
// Depends on pva_pkg, priority_voice_allocator and voice_table_checker.
module testbench;
  import pva_pkg::*;

  localparam int NUM_VOICES  = 32;
  localparam int CYCLE_LIMIT = 1000000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_operation = 1'b0;
  logic [HANDLE_W-1:0]   in_emitter_handle = '0;
  logic [ENTITY_W-1:0]   in_entity_number = '0;
  logic [SLOT_W-1:0]     in_slot = '0;
  logic [SOUND_W-1:0]    in_sound_id = '0;
  logic [PRIO_W-1:0]     in_priority_req = '0;
  logic                  in_no_restart = 1'b0;
  logic                  in_no_override = 1'b0;
  logic [TIME_W-1:0]     in_now = '0;
  logic [VIDX_W-1:0]     in_release_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_granted;
  logic [VIDX_W-1:0]     out_voice_index;
  logic                  out_stolen;
  int                    pending;
  int                    fail_count;

  logic                  hold_off = 1'b0;
  logic                  dense = 1'b0;
  int                    cycle_count = 0;
  int                    cur_active = 32;
  int                    cur_local = 0;
  int                    cur_listener = 0;
  logic [TIME_W-1:0]     time_now = '0;

  always #6 clk = ~clk;

  priority_voice_allocator #(.NUM_VOICES(NUM_VOICES)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_emitter_handle(in_emitter_handle), .in_entity_number(in_entity_number),
    .in_slot(in_slot), .in_sound_id(in_sound_id), .in_priority_req(in_priority_req),
    .in_no_restart(in_no_restart), .in_no_override(in_no_override), .in_now(in_now),
    .in_release_index(in_release_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_granted(out_granted),
    .out_voice_index(out_voice_index), .out_stolen(out_stolen)
  );

  voice_table_checker #(.NUM_VOICES(NUM_VOICES)) table_check (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_emitter_handle(in_emitter_handle), .in_entity_number(in_entity_number),
    .in_slot(in_slot), .in_sound_id(in_sound_id), .in_priority_req(in_priority_req),
    .in_no_restart(in_no_restart), .in_no_override(in_no_override), .in_now(in_now),
    .in_release_index(in_release_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_granted(out_granted),
    .out_voice_index(out_voice_index), .out_stolen(out_stolen),
    .pending(pending), .fail_count(fail_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: mostly short stalls, runs without any, now and then a long one.
  // One very long hold-off lets the block fill up and stall its input.
  initial begin
    int   span;
    int   roll;
    logic held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      roll = $urandom_range(0, 19);
      if (hold_off && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        span = 400;
      end else if (roll < 10) begin
        out_stall <= 1'b0;
        span = $urandom_range(1, 30);
      end else if (roll < 18) begin
        out_stall <= 1'b1;
        span = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;
        span = $urandom_range(8, 60);
      end
      repeat (span) @(posedge clk);
    end
  end

  // Random item biased toward a few emitters, the protected handle and entity and
  // a few priorities, so that same-slot hits, protection and ties come up often.
  function automatic pva_req_t random_item();
    pva_req_t item;
    int       roll;
    int       used;
    used = (cur_active > NUM_VOICES) ? NUM_VOICES : cur_active;
    roll = $urandom_range(0, 9);
    if (roll < 2)
      item.entry.handle = HANDLE_W'(cur_local);
    else if (roll < 8)
      item.entry.handle = HANDLE_W'($urandom_range(1, 4));
    else
      item.entry.handle = HANDLE_W'($urandom);
    roll = $urandom_range(0, 9);
    if (roll < 2)
      item.entry.entity = ENTITY_W'(cur_listener);
    else if (roll < 8)
      item.entry.entity = ENTITY_W'($urandom_range(0, 7));
    else
      item.entry.entity = ENTITY_W'($urandom);
    roll = $urandom_range(0, 9);
    if (roll < 4)
      item.entry.slot = '0;
    else if (roll < 9)
      item.entry.slot = SLOT_W'($urandom_range(1, 3));
    else
      item.entry.slot = SLOT_W'($urandom);
    item.entry.sound = ($urandom_range(0, 9) < 7) ? SOUND_W'($urandom_range(0, 3)) :
                                                     SOUND_W'($urandom);
    item.entry.prio = ($urandom_range(0, 9) < 6) ? PRIO_W'($urandom_range(0, 3) * 85) :
                                                    PRIO_W'($urandom);
    item.entry.no_restart = ($urandom_range(0, 3) == 0);
    item.entry.no_override = ($urandom_range(0, 3) == 0);
    roll = $urandom_range(0, 9);
    if (roll < 8) begin
      time_now = time_now + TIME_W'($urandom_range(0, 40));
      item.entry.alloc_time = time_now;
    end else if (roll == 8) begin
      item.entry.alloc_time = $urandom;
    end else begin
      item.entry.alloc_time = $urandom_range(0, 1) ? '1 : '0;
    end
    if (used > 0 && $urandom_range(0, 4) != 0)
      item.release_index = VIDX_W'($urandom_range(0, used - 1));
    else
      item.release_index = VIDX_W'($urandom);
    item.operation = ($urandom_range(0, 9) < 3) ? OP_RELEASE : OP_PICK;
    return item;
  endfunction

  // Offers one item after an optional idle gap and returns at the edge it is taken.
  // Valid stays high when the next item follows without a gap.
  task automatic send_item(input pva_req_t item);
    int gap;
    int roll;
    roll = $urandom_range(0, 19);
    if (dense || roll < 10)
      gap = 0;
    else if (roll < 17)
      gap = $urandom_range(1, 3);
    else if (roll < 19)
      gap = $urandom_range(4, 10);
    else
      gap = $urandom_range(20, 80);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= item.operation;
    in_emitter_handle <= item.entry.handle;
    in_entity_number <= item.entry.entity;
    in_slot <= item.entry.slot;
    in_sound_id <= item.entry.sound;
    in_priority_req <= item.entry.prio;
    in_no_restart <= item.entry.no_restart;
    in_no_override <= item.entry.no_override;
    in_now <= item.entry.alloc_time;
    in_release_index <= item.release_index;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic request_voice(input int handle, input int entity, input int slot,
                               input int sound, input int prio, input logic keep,
                               input logic own, input logic [TIME_W-1:0] stamp);
    pva_req_t item;
    item = random_item();
    item.operation = OP_PICK;
    item.entry.handle = HANDLE_W'(handle);
    item.entry.entity = ENTITY_W'(entity);
    item.entry.slot = SLOT_W'(slot);
    item.entry.sound = SOUND_W'(sound);
    item.entry.prio = PRIO_W'(prio);
    item.entry.no_restart = keep;
    item.entry.no_override = own;
    item.entry.alloc_time = stamp;
    send_item(item);
  endtask

  task automatic free_voice(input int index);
    pva_req_t item;
    item = random_item();
    item.operation = OP_RELEASE;
    item.release_index = VIDX_W'(index);
    send_item(item);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_item(random_item());
  endtask

  // Waits until every result is back, then writes all three registers.
  task automatic reconfigure(input int active, input int emitter, input int listener);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ACTIVE_CHANNELS;
    cfg_wdata <= CFG_DATA_W'(active);
    @(posedge clk);
    cfg_index <= CFG_LOCAL_EMITTER;
    cfg_wdata <= CFG_DATA_W'(emitter);
    @(posedge clk);
    cfg_index <= CFG_LISTENER_ENTITY;
    cfg_wdata <= CFG_DATA_W'(listener);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_active = active;
    cur_local = emitter;
    cur_listener = listener;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Four voices, the local emitter at the top handle, the listener at the top entity.
    reconfigure(4, 4095, 1023);
    free_voice(31);
    request_voice(4095, 5, 1, 10, 10, 1'b0, 1'b0, 100);
    request_voice(7, 1023, 0, 11, 10, 1'b0, 1'b0, 50);
    request_voice(9, 3, 2, 20, 200, 1'b1, 1'b0, 10);
    request_voice(9, 3, 3, 30, 5, 1'b0, 1'b1, 20);
    // All protected or more important than the request, so it is dropped.
    request_voice(1, 1, 0, 40, 0, 1'b0, 1'b0, 200);
    // The slot-3 voice refuses another sound; the lowest priority elsewhere goes.
    request_voice(9, 3, 3, 31, 255, 1'b0, 1'b0, 300);
    // Same emitter, slot and sound without the no-restart flag is taken at once.
    request_voice(9, 3, 3, 31, 255, 1'b0, 1'b0, 310);
    request_voice(4095, 5, 0, 12, 255, 1'b0, 1'b0, 320);
    request_voice(8, 1023, 0, 13, 255, 1'b0, 1'b0, 330);
    free_voice(2);
    free_voice(2);
    request_voice(5, 5, 0, 13, 7, 1'b1, 1'b1, 32'hFFFF_FFFF);
    free_voice(0);
    free_voice(1);
    free_voice(3);
    request_voice(2, 2, 0, 1, 50, 1'b0, 1'b0, 32'hFFFF_FFFF);
    request_voice(3, 2, 0, 1, 50, 1'b0, 1'b0, 32'h0000_0000);
    request_voice(4, 2, 0, 1, 50, 1'b0, 1'b0, 32'h8000_0000);
    request_voice(6, 6, 0, 2, 50, 1'b0, 1'b0, 100);
    // Equal priorities everywhere: the oldest allocation is stolen.
    request_voice(6, 6, 0, 2, 50, 1'b0, 1'b0, 400);

    reconfigure(32, 0, 0);
    dense = 1'b0;
    run_random(100);
    hold_off <= 1'b1;
    run_random(150);

    reconfigure(1, 4095, 1023);
    dense = ($urandom_range(0, 3) == 0);
    run_random(80);

    reconfigure(8, $urandom_range(0, 4095), $urandom_range(0, 1023));
    dense = ($urandom_range(0, 3) == 0);
    run_random(200);

    // Counts above the table size saturate at the table size.
    reconfigure(63, 2048, 512);
    dense = ($urandom_range(0, 3) == 0);
    run_random(150);

    // No voice takes part: every pick drops, releases still work.
    reconfigure(0, 1, 1);
    run_random(40);

    reconfigure(3, $urandom_range(0, 4095), $urandom_range(0, 1023));
    dense = 1'b1;
    run_random(150);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
